/* hw/rtl/tbpd_pkg.sv */
// Package for the ternary-binary popcount dot product block.
// Field widths, lane limits and parameter defaults; no dependencies.
package tbpd_pkg;

  // Fixed item layout: eight column bytes per item.
  localparam int unsigned NumCols  = 8;
  localparam int unsigned ColW     = 8;
  localparam int unsigned ColIdxW  = 3;
  localparam int unsigned DotW     = 20;

  // Parameter defaults for the top level.
  localparam int unsigned LanesDef  = 8;
  localparam int unsigned SumWDef   = 20;

endpackage

/* hw/rtl/tbpd_in_if.sv */
// Input channel: ternary row masks, eight column bytes and run marker.
// Depends on tbpd_pkg for field widths.
interface tbpd_in_if;
  logic                      valid;
  logic                      ready;
  logic [tbpd_pkg::ColW-1:0] plus_mask;
  logic [tbpd_pkg::ColW-1:0] minus_mask;
  logic [tbpd_pkg::ColW-1:0] col0_bits;
  logic [tbpd_pkg::ColW-1:0] col1_bits;
  logic [tbpd_pkg::ColW-1:0] col2_bits;
  logic [tbpd_pkg::ColW-1:0] col3_bits;
  logic [tbpd_pkg::ColW-1:0] col4_bits;
  logic [tbpd_pkg::ColW-1:0] col5_bits;
  logic [tbpd_pkg::ColW-1:0] col6_bits;
  logic [tbpd_pkg::ColW-1:0] col7_bits;
  logic                      last_step;

  modport source (
    output valid, plus_mask, minus_mask, col0_bits, col1_bits, col2_bits, col3_bits,
           col4_bits, col5_bits, col6_bits, col7_bits, last_step,
    input  ready
  );
  modport sink (
    input  valid, plus_mask, minus_mask, col0_bits, col1_bits, col2_bits, col3_bits,
           col4_bits, col5_bits, col6_bits, col7_bits, last_step,
    output ready
  );
endinterface

/* hw/rtl/tbpd_out_if.sv */
// Output channel: one lane dot product per transfer.
// Depends on tbpd_pkg for field widths.
interface tbpd_out_if;
  logic                              valid;
  logic                              ready;
  logic [tbpd_pkg::ColIdxW-1:0]      column_index;
  logic signed [tbpd_pkg::DotW-1:0]  dot_value;
  logic                              last_result;

  modport source (output valid, column_index, dot_value, last_result, input ready);
  modport sink   (input  valid, column_index, dot_value, last_result, output ready);
endinterface

/* hw/rtl/ternary_binary_popcount_dot.sv */
// Ternary-binary popcount dot product, one lane per column.
// An item is accumulated at its input transfer; a run's last item has its first
// result offered the next cycle, then one per cycle while ready; min(LANES, 8) in all.
// Throughput: one item per cycle; a last item waits only while the previous run's
// results are still being sent (the single result buffer sets this).
// Reset: asynchronous, active low; clears accumulators and the result buffer state.
module ternary_binary_popcount_dot #(
  parameter int unsigned LANES     = tbpd_pkg::LanesDef,
  parameter int unsigned SUM_WIDTH = tbpd_pkg::SumWDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tbpd_in_if.sink   in_i,
  tbpd_out_if.source out_o
);

  // Only eight column bytes exist in an item; extra lanes would have no data.
  localparam int unsigned UsedLanes = (LANES < tbpd_pkg::NumCols) ? LANES : tbpd_pkg::NumCols;

  logic [tbpd_pkg::ColW-1:0] cols [tbpd_pkg::NumCols];
  logic [SUM_WIDTH-1:0]      lane_sum [UsedLanes];
  logic                      accept;
  logic                      can_load;

  assign cols[0] = in_i.col0_bits;
  assign cols[1] = in_i.col1_bits;
  assign cols[2] = in_i.col2_bits;
  assign cols[3] = in_i.col3_bits;
  assign cols[4] = in_i.col4_bits;
  assign cols[5] = in_i.col5_bits;
  assign cols[6] = in_i.col6_bits;
  assign cols[7] = in_i.col7_bits;

  // Plain items are always taken. A last item hands its sums to the result
  // buffer, so it waits until the buffer is empty or sends its final transfer.
  assign in_i.ready = !in_i.last_step || can_load;
  assign accept     = in_i.valid && in_i.ready;

  // Lanes: each accumulates matches minus mismatches, saturating; cleared
  // after a last item, whose saturated sum goes to the buffer.
  for (genvar l = 0; l < UsedLanes; l++) begin : g_lane
    tbpd_lane #(
      .SUM_WIDTH (SUM_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (accept),
      .clear_i (in_i.last_step),
      .plus_i  (in_i.plus_mask),
      .minus_i (in_i.minus_mask),
      .col_i   (cols[l]),
      .sum_o   (lane_sum[l])
    );
  end

  // Merge: snapshot of all lane sums, sent one transfer per lane.
  tbpd_drain #(
    .USED_LANES (UsedLanes),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_drain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && in_i.last_step),
    .sums_i     (lane_sum),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

/* hw/rtl/tbpd_lane.sv */
// One column lane: sign-match popcounts and a saturating accumulator.
// Depends on tbpd_pkg.
module tbpd_lane #(
  parameter int unsigned SUM_WIDTH = tbpd_pkg::SumWDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        clear_i,
  input  logic [tbpd_pkg::ColW-1:0]   plus_i,
  input  logic [tbpd_pkg::ColW-1:0]   minus_i,
  input  logic [tbpd_pkg::ColW-1:0]   col_i,
  output logic [SUM_WIDTH-1:0]        sum_o
);

  logic [SUM_WIDTH-1:0] acc_q, acc_d;
  logic [tbpd_pkg::ColW-1:0] same, diff;
  logic [3:0] pc_same, pc_diff;
  logic [4:0] delta;
  logic [SUM_WIDTH:0] wide;
  logic [SUM_WIDTH-1:0] sat;

  assign same = (plus_i | col_i) & (minus_i | ~col_i);
  assign diff = (plus_i | ~col_i) & (minus_i | col_i);

  always_comb begin
    pc_same = '0;
    pc_diff = '0;
    for (int i = 0; i < tbpd_pkg::ColW; i++) begin
      pc_same = pc_same + 4'(same[i]);
      pc_diff = pc_diff + 4'(diff[i]);
    end
  end

  // delta lies in -8..8
  assign delta = {1'b0, pc_same} - {1'b0, pc_diff};
  assign wide  = {acc_q[SUM_WIDTH-1], acc_q} + {{(SUM_WIDTH-4){delta[4]}}, delta};

  always_comb begin
    if (wide[SUM_WIDTH] != wide[SUM_WIDTH-1]) begin
      sat = wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
    end else begin
      sat = wide[SUM_WIDTH-1:0];
    end
  end

  assign sum_o = sat;

  always_comb begin
    acc_d = acc_q;
    if (step_i) begin
      acc_d = clear_i ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

/* hw/rtl/tbpd_drain.sv */
// Merge stage: holds the lane sums of a finished run and sends them in lane order.
// Depends on tbpd_pkg and tbpd_out_if.
module tbpd_drain #(
  parameter int unsigned USED_LANES = tbpd_pkg::LanesDef,
  parameter int unsigned SUM_WIDTH  = tbpd_pkg::SumWDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [SUM_WIDTH-1:0] sums_i [USED_LANES],
  output logic                 can_load_o,
  tbpd_out_if.source           out_o
);

  localparam int unsigned IdxW = (USED_LANES > 1) ? $clog2(USED_LANES) : 1;

  logic [SUM_WIDTH-1:0] snap_q [USED_LANES];
  logic                 busy_q;
  logic [IdxW-1:0]      idx_q;
  logic                 last_beat;
  logic                 fire;
  logic [SUM_WIDTH-1:0] cur;

  assign last_beat  = (idx_q == IdxW'(USED_LANES - 1));
  assign fire       = busy_q & out_o.ready;
  assign can_load_o = !busy_q || (fire && last_beat);
  assign cur        = snap_q[idx_q];

  assign out_o.valid        = busy_q;
  assign out_o.column_index = tbpd_pkg::ColIdxW'(idx_q);
  assign out_o.last_result  = last_beat;

  if (SUM_WIDTH >= tbpd_pkg::DotW) begin : g_trunc
    assign out_o.dot_value = cur[tbpd_pkg::DotW-1:0];
  end else begin : g_sext
    assign out_o.dot_value = {{(tbpd_pkg::DotW-SUM_WIDTH){cur[SUM_WIDTH-1]}}, cur};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= sums_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fire) begin
      if (last_beat) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

endmodule

/* sim/tbpd_dot_checker.sv */
// Checker for the ternary-binary popcount dot block: watches both channels, keeps
// lane sums of its own and compares every lane result in arrival order.
// Depends on tbpd_pkg, tbpd_in_if and tbpd_out_if.
module tbpd_dot_checker #(
  parameter int unsigned LANES     = tbpd_pkg::LanesDef,
  parameter int unsigned SUM_WIDTH = tbpd_pkg::SumWDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tbpd_in_if   in_mon_i,
  tbpd_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   clamped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned UsedLanes = (LANES < tbpd_pkg::NumCols) ? LANES : tbpd_pkg::NumCols;
  localparam longint SumMax = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
  localparam longint SumMin = -SumMax - 1;

  typedef struct packed {
    logic [tbpd_pkg::ColIdxW-1:0]     column_index;
    logic signed [tbpd_pkg::DotW-1:0] dot_value;
    logic                             last_result;
  } lane_result_t;

  longint       lane_sum [tbpd_pkg::NumCols];
  lane_result_t lane_result_q [$];

  // Same-sign positions minus opposite-sign positions; a position with both
  // masks set lands in both counts and so nets to zero.
  function automatic int sign_balance(input logic [tbpd_pkg::ColW-1:0] p, q, b);
    return $countones((p | b) & (q | ~b)) - $countones((p | ~b) & (q | b));
  endfunction

  function automatic longint clamp_sum(input longint v);
    if (v > SumMax) return SumMax;
    if (v < SumMin) return SumMin;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lane_result_t              got;
    lane_result_t              want;
    logic [tbpd_pkg::ColW-1:0] col_byte [tbpd_pkg::NumCols];
    if (!rst_ni) begin
      foreach (lane_sum[j]) lane_sum[j] = 0;
      lane_result_q.delete();
    end else begin
      // Results first: a result never belongs to the item taken at the same edge.
      if (out_mon_i.valid && out_mon_i.ready) begin
        got.column_index = out_mon_i.column_index;
        got.dot_value    = out_mon_i.dot_value;
        got.last_result  = out_mon_i.last_result;
        if (lane_result_q.size() == 0) begin
          report_mismatch($sformatf("lane %0d result %0d with nothing pending",
                                    got.column_index, got.dot_value));
        end else begin
          want = lane_result_q.pop_front();
          checked_o++;
          if (want.dot_value == SumMax || want.dot_value == SumMin) clamped_o++;
          if (got.column_index !== want.column_index)
            report_mismatch($sformatf("column_index %0d, want %0d",
                                      got.column_index, want.column_index));
          if (got.dot_value !== want.dot_value)
            report_mismatch($sformatf("lane %0d dot_value %0d, want %0d",
                                      want.column_index, got.dot_value, want.dot_value));
          if (got.last_result !== want.last_result)
            report_mismatch($sformatf("lane %0d last_result %b, want %b",
                                      want.column_index, got.last_result,
                                      want.last_result));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        col_byte = '{in_mon_i.col0_bits, in_mon_i.col1_bits, in_mon_i.col2_bits,
                     in_mon_i.col3_bits, in_mon_i.col4_bits, in_mon_i.col5_bits,
                     in_mon_i.col6_bits, in_mon_i.col7_bits};
        for (int j = 0; j < UsedLanes; j++)
          lane_sum[j] = clamp_sum(lane_sum[j] + sign_balance(in_mon_i.plus_mask,
                                                             in_mon_i.minus_mask,
                                                             col_byte[j]));
        if (in_mon_i.last_step) begin
          for (int j = 0; j < UsedLanes; j++) begin
            want.column_index = tbpd_pkg::ColIdxW'(j);
            want.dot_value    = tbpd_pkg::DotW'(lane_sum[j]);
            want.last_result  = (j == UsedLanes - 1);
            lane_result_q.push_back(want);
            lane_sum[j] = 0;
          end
        end
      end
    end
    pending_o = lane_result_q.size();
  end

endmodule

/* sim/ternary_binary_popcount_dot_test.sv */
// Testbench top for the ternary-binary popcount dot block: drives row steps,
// stalls the result side and gives the verdict from the checker's count.
// Depends on tbpd_pkg, both channel interfaces, the block and tbpd_dot_checker.
module ternary_binary_popcount_dot_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Lanes = tbpd_pkg::LanesDef;
  localparam int unsigned SumW  = tbpd_pkg::SumWDef;
  localparam int RandItems = 300;
  // Quiet cycles allowed: far above the longest gap plus a full drain of stalled results.
  localparam int IdleLimit = 2000;

  // Column bytes, lane 0 in the low byte.
  localparam logic [tbpd_pkg::NumCols*tbpd_pkg::ColW-1:0] MixedCols = 64'h8001_55AA_F00F_FF00;
  localparam logic [tbpd_pkg::NumCols*tbpd_pkg::ColW-1:0] AltCols   = 64'hFF00_FF00_FF00_FF00;

  typedef struct packed {
    logic [tbpd_pkg::ColW-1:0]                        plus_mask;
    logic [tbpd_pkg::ColW-1:0]                        minus_mask;
    logic [tbpd_pkg::NumCols-1:0][tbpd_pkg::ColW-1:0] cols;
    logic                                             last_step;
  } row_step_t;

  logic clk_i;
  logic rst_ni;

  tbpd_in_if  in_w ();
  tbpd_out_if out_w ();

  int fail_count;
  int pending_results;
  int checked_results;
  int clamped_results;

  bit sender_idle_on;
  bit receiver_stall_on;
  int items_sent;
  int runs_sent;
  int quiet_cycles;

  ternary_binary_popcount_dot #(
    .LANES    (Lanes),
    .SUM_WIDTH(SumW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_w),
    .out_o (out_w)
  );

  tbpd_dot_checker #(
    .LANES    (Lanes),
    .SUM_WIDTH(SumW)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_w),
    .out_mon_i   (out_w),
    .fail_count_o(fail_count),
    .pending_o   (pending_results),
    .checked_o   (checked_results),
    .clamped_o   (clamped_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: any stretch this long with no transfer on either side is a hang.
  always @(posedge clk_i) begin
    if (rst_ni && !((in_w.valid && in_w.ready) || (out_w.valid && out_w.ready))) begin
      quiet_cycles++;
      if (quiet_cycles == IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  // Result side: ready by default, with random stall bursts when stalls are
  // enabled. Sole driver of out_w.ready; changes only at falling edges.
  initial begin
    out_w.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (receiver_stall_on && $urandom_range(0, 4) == 0) begin
        out_w.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      out_w.ready = 1'b1;
    end
  end

  function automatic row_step_t make_step(input logic [tbpd_pkg::ColW-1:0] p, q,
                                          input logic [tbpd_pkg::NumCols*tbpd_pkg::ColW-1:0] cols,
                                          input logic last);
    row_step_t s;
    s.plus_mask  = p;
    s.minus_mask = q;
    s.cols       = cols;
    s.last_step  = last;
    return s;
  endfunction

  // Mostly proper ternary rows (disjoint masks), with some overlapping masks,
  // solid rows and zero rows mixed in. Column bytes are always fully random.
  function automatic row_step_t random_step(input logic last);
    row_step_t s;
    int        pick;
    pick        = $urandom_range(0, 9);
    s.cols      = {$urandom, $urandom};
    s.last_step = last;
    s.plus_mask = 8'($urandom_range(0, 255));
    if (pick < 2) begin
      s.minus_mask = 8'($urandom_range(0, 255));
    end else if (pick < 7) begin
      s.minus_mask = 8'($urandom_range(0, 255)) & ~s.plus_mask;
    end else if (pick == 7) begin
      s.plus_mask  = 8'hFF;
      s.minus_mask = 8'h00;
    end else if (pick == 8) begin
      s.plus_mask  = 8'h00;
      s.minus_mask = 8'hFF;
    end else begin
      s.plus_mask  = 8'h00;
      s.minus_mask = 8'h00;
    end
    return s;
  endfunction

  // One input transfer. An optional gap with valid low comes first; valid then
  // stays high until the block takes the step at a rising edge.
  task automatic send_step(input row_step_t s);
    @(negedge clk_i);
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      in_w.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_w.plus_mask  = s.plus_mask;
    in_w.minus_mask = s.minus_mask;
    in_w.col0_bits  = s.cols[0];
    in_w.col1_bits  = s.cols[1];
    in_w.col2_bits  = s.cols[2];
    in_w.col3_bits  = s.cols[3];
    in_w.col4_bits  = s.cols[4];
    in_w.col5_bits  = s.cols[5];
    in_w.col6_bits  = s.cols[6];
    in_w.col7_bits  = s.cols[7];
    in_w.last_step  = s.last_step;
    in_w.valid      = 1'b1;
    do @(posedge clk_i); while (!in_w.ready);
    items_sent++;
    if (s.last_step) runs_sent++;
  endtask

  // Drop valid and hold off until every predicted lane result has been seen.
  task automatic drain_results;
    @(negedge clk_i);
    in_w.valid = 1'b0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  task automatic random_run(input bit with_idling);
    int run_len;
    // Mostly short runs so results keep coming; now and then a longer one.
    run_len           = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16)
                                                    : $urandom_range(1, 4);
    sender_idle_on    = with_idling && ($urandom_range(0, 3) != 0);
    receiver_stall_on = with_idling && ($urandom_range(0, 3) != 0);
    for (int k = 0; k < run_len; k++) send_step(random_step(k == run_len - 1));
  endtask

  initial begin : stimulus
    rst_ni          = 1'b0;
    in_w.valid      = 1'b0;
    in_w.plus_mask  = '0;
    in_w.minus_mask = '0;
    in_w.col0_bits  = '0;
    in_w.col1_bits  = '0;
    in_w.col2_bits  = '0;
    in_w.col3_bits  = '0;
    in_w.col4_bits  = '0;
    in_w.col5_bits  = '0;
    in_w.col6_bits  = '0;
    in_w.col7_bits  = '0;
    in_w.last_step  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners, no idling on either side.
    // Zero row alone: all lanes must come out as zero.
    send_step(make_step(8'h00, 8'h00, {tbpd_pkg::NumCols{8'hFF}}, 1'b1));
    // All-plus row over mixed columns, then a row with both masks set everywhere
    // (net zero), then all-minus over all-set columns to close the run.
    send_step(make_step(8'hFF, 8'h00, MixedCols, 1'b0));
    send_step(make_step(8'hFF, 8'hFF, {$urandom, $urandom}, 1'b0));
    send_step(make_step(8'h00, 8'hFF, {tbpd_pkg::NumCols{8'hFF}}, 1'b1));
    // Interleaved and partly overlapping masks.
    send_step(make_step(8'hAA, 8'h55, MixedCols, 1'b1));
    send_step(make_step(8'h0F, 8'hF0, ~MixedCols, 1'b0));
    send_step(make_step(8'h3C, 8'hC3, MixedCols, 1'b1));
    send_step(make_step(8'hF0, 8'h3C, {$urandom, $urandom}, 1'b1));
    // Single-step runs back to back: extremes +8 and -8 per lane, and a last step
    // that must wait while the previous run's results are still going out.
    send_step(make_step(8'hFF, 8'h00, {tbpd_pkg::NumCols{8'h00}}, 1'b1));
    send_step(make_step(8'h00, 8'hFF, {tbpd_pkg::NumCols{8'h00}}, 1'b1));
    send_step(make_step(8'hFF, 8'h00, {tbpd_pkg::NumCols{8'hFF}}, 1'b1));
    send_step(make_step(8'h00, 8'hFF, {tbpd_pkg::NumCols{8'hFF}}, 1'b1));
    // A six-step run that builds up to +48 / -48 on alternate lanes.
    for (int k = 0; k < 6; k++) send_step(make_step(8'hFF, 8'h00, AltCols, k == 5));
    // Low single bits against high single bits.
    send_step(make_step(8'h01, 8'h80, {tbpd_pkg::NumCols{8'h81}}, 1'b0));
    send_step(make_step(8'h80, 8'h01, {tbpd_pkg::NumCols{8'h01}}, 1'b1));

    // Pressure: sender holds off until the block has nothing left to send.
    drain_results();

    // Random runs, idling switched on and off run by run.
    while (items_sent < RandItems) random_run(1'b1);
    drain_results();

    // Last part, no idling at all: random runs back to back.
    sender_idle_on    = 1'b0;
    receiver_stall_on = 1'b0;
    for (int k = 0; k < 6; k++) random_run(1'b0);

    drain_results();
    repeat (2 * tbpd_pkg::NumCols + 4) @(posedge clk_i);

    $display("covered %0d row steps in %0d runs: directed corners, random runs under",
             items_sent, runs_sent);
    $display("idling and stalls, then an idle-free tail; %0d lane results, %0d at a range end",
             checked_results, clamped_results);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
